/* src/gdd_pkg.sv */
// ----------------------------------------------------------------------------
// gdd_pkg
// Shared types and constants of the gaze region dwell detector: configuration
// register indexes and reset values, the event record and the queue push bundle.
// ----------------------------------------------------------------------------
package gdd_pkg;

    // default parameter values
    localparam int MAX_FIXATIONS_DEF   = 32;
    localparam int COORD_FRAC_BITS_DEF = 4;

    // field widths
    localparam int BOUND_W  = 11;
    localparam int THR_W    = 16;
    localparam int RID_W    = 2;
    localparam int COORD_W  = 16;
    localparam int TIME_W   = 32;
    localparam int IDX_W    = 5;
    localparam int SECS_W   = 23;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 64;

    // register reset values
    localparam logic [BOUND_W-1:0] LEFT_RST   = 11'd288;
    localparam logic [BOUND_W-1:0] RIGHT_RST  = 11'd811;
    localparam logic [BOUND_W-1:0] TOP_RST    = 11'd597;
    localparam logic [BOUND_W-1:0] BOTTOM_RST = 11'd1051;
    localparam logic [THR_W-1:0]   THR_RST    = 16'd3000;
    localparam logic [RID_W-1:0]   RID_RST    = 2'd0;

    // divide by 1000: q = (n * ceil(2^38 / 1000)) >> 38, exact for 32-bit n
    localparam int RECIP_W  = 29;
    localparam logic [RECIP_W-1:0] RECIP_1000 = 29'd274877907;
    localparam int DIV_SHIFT = 38;
    localparam int PROD_W    = TIME_W + RECIP_W;

    // output queue depth
    localparam int OUT_DEPTH = 4;

    // configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_LEFT      = 3'd0,
        REG_RIGHT     = 3'd1,
        REG_TOP       = 3'd2,
        REG_BOTTOM    = 3'd3,
        REG_THRESHOLD = 3'd4,
        REG_REGION_ID = 3'd5
    } cfg_reg_t;

    // record kinds
    localparam logic KIND_BEGIN  = 1'b0;
    localparam logic KIND_LENGTH = 1'b1;

    // per-sample outcome of the dwell tracker
    typedef struct packed {
        logic              beg_v;
        logic [IDX_W-1:0]  beg_idx;
        logic              end_v;
        logic [IDX_W-1:0]  end_idx;
        logic              ovf;
        logic [TIME_W-1:0] len;
        logic [TIME_W-1:0] diff;
    } evt_t;

    // one output record
    typedef struct packed {
        logic              kind;
        logic [IDX_W-1:0]  idx;
        logic [RID_W-1:0]  region;
        logic [SECS_W-1:0] secs;
        logic [TIME_W-1:0] len;
        logic              ovf;
        logic              last;
    } rec_t;

    // up to two records pushed in one cycle; v1 implies v0
    typedef struct packed {
        logic v0;
        logic v1;
        rec_t r0;
        rec_t r1;
    } push_t;

endpackage

/* src/gaze_region_dwell_detector_core.sv */
// A sample passes the input register, the event register and the queue to m_tvalid.
// Throughput: one sample per cycle with room in the queue; a sample giving two records
// takes two output beats, so the m_tready rate and record count set the sustained pace.
// Reset (rst_n low, asynchronous): dwell state, fixation counter and queue cleared,
// configuration registers back to their defaults.
// ----------------------------------------------------------------------------
// gaze_region_dwell_detector_core
// Gaze samples enter an input register, the dwell tracker decides begin and
// length records, a reciprocal multiply turns the start offset into seconds,
// and the records queue up for the result stream.
// ----------------------------------------------------------------------------
module gaze_region_dwell_detector_core #(
    parameter int MAX_FIXATIONS   = gdd_pkg::MAX_FIXATIONS_DEF,
    parameter int COORD_FRAC_BITS = gdd_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [gdd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [gdd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // sample stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // x_position[15:0], y_position[31:16], time_ms[63:32]
    input  logic [gdd_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                              s_tlast,   // last_of_run
    input  logic                              s_tuser,   // first_of_run
    // record stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // fixation_index[4:0], region_out[6:5], start_seconds[29:7],
    // length_ms[61:30], store_overflow[62], zero[63]
    output logic [gdd_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tlast,   // last_result
    output logic                              m_tuser    // event_kind
);
    import gdd_pkg::*;

    // configuration registers
    logic [BOUND_W-1:0] left_reg, right_reg, top_reg, bottom_reg;
    logic [THR_W-1:0]   thr_reg;
    logic [RID_W-1:0]   rid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= LEFT_RST;
            right_reg  <= RIGHT_RST;
            top_reg    <= TOP_RST;
            bottom_reg <= BOTTOM_RST;
            thr_reg    <= THR_RST;
            rid_reg    <= RID_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_LEFT:      left_reg   <= cfg_wdata[BOUND_W-1:0];
                REG_RIGHT:     right_reg  <= cfg_wdata[BOUND_W-1:0];
                REG_TOP:       top_reg    <= cfg_wdata[BOUND_W-1:0];
                REG_BOTTOM:    bottom_reg <= cfg_wdata[BOUND_W-1:0];
                REG_THRESHOLD: thr_reg    <= cfg_wdata[THR_W-1:0];
                REG_REGION_ID: rid_reg    <= cfg_wdata[RID_W-1:0];
                default:       ;
            endcase
        end
    end

    // pipeline control
    logic s1_valid_reg, s2_valid_reg;
    logic q_room;
    logic s1_move, s2_move, s2_free, accept;

    assign s2_move  = s2_valid_reg && q_room;
    assign s2_free  = !s2_valid_reg || s2_move;
    assign s1_move  = s1_valid_reg && s2_free;
    assign s_tready = !s1_valid_reg || s1_move;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_move)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    // input register
    logic signed [COORD_W-1:0] x_reg, y_reg;
    logic        [TIME_W-1:0]  t_reg;
    logic                      first_reg, last_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg     <= $signed(s_tdata[15:0]);
            y_reg     <= $signed(s_tdata[31:16]);
            t_reg     <= s_tdata[63:32];
            first_reg <= s_tuser;
            last_reg  <= s_tlast;
        end
    end

    // dwell tracking
    evt_t evt;

    gdd_tracker #(
        .MAX_FIXATIONS   (MAX_FIXATIONS),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_tracker (
        .clk                (clk),
        .rst_n              (rst_n),
        .step               (s1_move),
        .x_position         (x_reg),
        .y_position         (y_reg),
        .time_ms            (t_reg),
        .first_of_run       (first_reg),
        .last_of_run        (last_reg),
        .region_left        (left_reg),
        .region_right       (right_reg),
        .region_top         (top_reg),
        .region_bottom      (bottom_reg),
        .dwell_threshold_ms (thr_reg),
        .evt                (evt)
    );

    // event register
    evt_t             s2_evt_reg;
    logic [RID_W-1:0] s2_rid_reg;

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_evt_reg <= evt;
            s2_rid_reg <= rid_reg;
        end
    end

    // start offset in whole seconds by reciprocal multiply
    logic [PROD_W-1:0] prod;
    logic [SECS_W-1:0] secs;

    assign prod = PROD_W'(s2_evt_reg.diff) * PROD_W'(RECIP_1000);
    assign secs = prod[DIV_SHIFT +: SECS_W];

    // records into the queue, begin before length
    push_t push;
    rec_t  beg_rec, len_rec;

    always_comb
    begin
        beg_rec        = '0;
        beg_rec.kind   = KIND_BEGIN;
        beg_rec.idx    = s2_evt_reg.beg_idx;
        beg_rec.region = s2_rid_reg;
        beg_rec.secs   = secs;
        beg_rec.ovf    = s2_evt_reg.ovf;
        beg_rec.last   = !s2_evt_reg.end_v;

        len_rec        = '0;
        len_rec.kind   = KIND_LENGTH;
        len_rec.idx    = s2_evt_reg.end_idx;
        len_rec.region = s2_rid_reg;
        len_rec.secs   = secs;
        len_rec.len    = s2_evt_reg.len;
        len_rec.ovf    = s2_evt_reg.ovf;
        len_rec.last   = 1'b1;

        push = '0;
        if (s2_move)
        begin
            if (s2_evt_reg.beg_v)
            begin
                push.v0 = 1'b1;
                push.r0 = beg_rec;
                push.v1 = s2_evt_reg.end_v;
                push.r1 = len_rec;
            end
            else
            begin
                push.v0 = s2_evt_reg.end_v;
                push.r0 = len_rec;
            end
        end
    end

    gdd_out_queue u_out_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .room     (q_room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

/* src/gdd_tracker.sv */
// ----------------------------------------------------------------------------
// gdd_tracker
// Dwell state of one region: region test, dwell start, qualification against
// the threshold, fixation numbering, and the begin/length decision per sample.
// ----------------------------------------------------------------------------
module gdd_tracker #(
    parameter int MAX_FIXATIONS   = gdd_pkg::MAX_FIXATIONS_DEF,
    parameter int COORD_FRAC_BITS = gdd_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step,
    input  logic signed [gdd_pkg::COORD_W-1:0]  x_position,
    input  logic signed [gdd_pkg::COORD_W-1:0]  y_position,
    input  logic        [gdd_pkg::TIME_W-1:0]   time_ms,
    input  logic                                first_of_run,
    input  logic                                last_of_run,
    input  logic        [gdd_pkg::BOUND_W-1:0]  region_left,
    input  logic        [gdd_pkg::BOUND_W-1:0]  region_right,
    input  logic        [gdd_pkg::BOUND_W-1:0]  region_top,
    input  logic        [gdd_pkg::BOUND_W-1:0]  region_bottom,
    input  logic        [gdd_pkg::THR_W-1:0]    dwell_threshold_ms,
    output gdd_pkg::evt_t                       evt
);
    import gdd_pkg::*;

    localparam int CNT_W = $clog2(MAX_FIXATIONS + 1);
    // compare width: holds a shifted bound plus sign, and the sign-extended sample
    localparam int CW = (BOUND_W + 1 + COORD_FRAC_BITS > COORD_W + 1) ?
                        (BOUND_W + 1 + COORD_FRAC_BITS) : (COORD_W + 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_FIXATIONS);
    localparam logic [IDX_W-1:0] IDX_FULL = IDX_W'(MAX_FIXATIONS - 1);

    function automatic logic [TIME_W-1:0] sat_sub(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        return (a >= b) ? (a - b) : '0;
    endfunction

    logic              inside_reg, inside_next;
    logic              qual_reg, qual_next;
    logic              over_reg, over_next;
    logic [TIME_W-1:0] start_reg, start_next;
    logic [TIME_W-1:0] last_in_reg, last_in_next;
    logic [TIME_W-1:0] base_reg, base_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic signed [CW-1:0] xs, ys, lb, rb, tb, bb;
    logic                 hit;
    logic                 fin;

    // region bounds scaled to coordinate fixed point
    always_comb
    begin
        xs = CW'(x_position);
        ys = CW'(y_position);
        lb = $signed(CW'(region_left)   << COORD_FRAC_BITS);
        rb = $signed(CW'(region_right)  << COORD_FRAC_BITS);
        tb = $signed(CW'(region_top)    << COORD_FRAC_BITS);
        bb = $signed(CW'(region_bottom) << COORD_FRAC_BITS);
        hit = (lb < xs) && (xs < rb) && (tb < ys) && (ys < bb);
    end

    // dwell update for the current sample
    always_comb
    begin
        inside_next  = inside_reg & ~first_of_run;
        qual_next    = qual_reg & ~first_of_run;
        over_next    = over_reg & ~first_of_run;
        base_next    = first_of_run ? time_ms : base_reg;
        start_next   = start_reg;
        last_in_next = last_in_reg;
        cnt_next     = cnt_reg;
        evt          = '0;

        if (hit)
        begin
            if (!inside_next)
            begin
                inside_next = 1'b1;
                qual_next   = 1'b0;
                over_next   = 1'b0;
                start_next  = time_ms;
            end
            last_in_next = time_ms;
            if (!qual_next &&
                sat_sub(time_ms, start_next) >= TIME_W'(dwell_threshold_ms))
            begin
                evt.beg_v = 1'b1;
                qual_next = 1'b1;
                if (cnt_next < CNT_MAX)
                begin
                    evt.beg_idx = IDX_W'(cnt_next);
                    cnt_next    = cnt_next + CNT_W'(1);
                    over_next   = 1'b0;
                end
                else
                begin
                    evt.beg_idx = IDX_FULL;
                    over_next   = 1'b1;
                end
            end
        end

        // leaving the region or end of pass closes the dwell
        fin         = (!hit || last_of_run) && inside_next;
        evt.end_v   = fin && qual_next;
        evt.end_idx = (cnt_next == '0) ? '0 : IDX_W'(cnt_next - CNT_W'(1));
        evt.ovf     = over_next;
        evt.len     = sat_sub(last_in_next, start_next);
        evt.diff    = sat_sub(start_next, base_next);
        if (fin)
        begin
            inside_next = 1'b0;
            qual_next   = 1'b0;
            over_next   = 1'b0;
        end
    end

    // state registers, advanced once per sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg  <= 1'b0;
            qual_reg    <= 1'b0;
            over_reg    <= 1'b0;
            start_reg   <= '0;
            last_in_reg <= '0;
            base_reg    <= '0;
            cnt_reg     <= '0;
        end
        else if (step)
        begin
            inside_reg  <= inside_next;
            qual_reg    <= qual_next;
            over_reg    <= over_next;
            start_reg   <= start_next;
            last_in_reg <= last_in_next;
            base_reg    <= base_next;
            cnt_reg     <= cnt_next;
        end
    end

    a_qual_in_dwell: assert property (@(posedge clk) disable iff (!rst_n)
        qual_reg |-> inside_reg)
        else $error("qualified flag set outside a dwell");

    a_over_qual: assert property (@(posedge clk) disable iff (!rst_n)
        over_reg |-> qual_reg)
        else $error("overflow flag set on an unqualified dwell");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_MAX)
        else $error("fixation counter beyond capacity");

endmodule

/* src/gdd_out_queue.sv */
// ----------------------------------------------------------------------------
// gdd_out_queue
// Small record queue before the result stream. Takes up to two records per
// cycle, hands out one beat per ready cycle, and reports room for two more.
// ----------------------------------------------------------------------------
module gdd_out_queue (
    input  logic                               clk,
    input  logic                               rst_n,
    input  gdd_pkg::push_t                     push,
    output logic                               room,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // fixation_index[4:0], region_out[6:5], start_seconds[29:7],
    // length_ms[61:30], store_overflow[62], zero[63]
    output logic [gdd_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                               m_tlast,   // last_result
    output logic                               m_tuser    // event_kind
);
    import gdd_pkg::*;

    localparam int PTR_W  = $clog2(OUT_DEPTH);
    localparam int QCNT_W = $clog2(OUT_DEPTH + 1);

    rec_t              mem [OUT_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              pop;
    rec_t              head;

    assign pop  = m_tvalid && m_tready;
    assign room = count_reg <= QCNT_W'(OUT_DEPTH - 2);
    assign count_next = count_reg + QCNT_W'(push.v0) + QCNT_W'(push.v1) - QCNT_W'(pop);

    // record storage
    always_ff @(posedge clk)
    begin
        if (push.v0)
        begin
            mem[wr_ptr_reg] <= push.r0;
        end
        if (push.v1)
        begin
            mem[wr_ptr_reg + PTR_W'(1)] <= push.r1;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push.v0) + PTR_W'(push.v1);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(pop);
            count_reg  <= count_next;
        end
    end

    // head record onto the stream
    assign head     = mem[rd_ptr_reg];
    assign m_tvalid = count_reg != '0;
    assign m_tdata  = {1'b0, head.ovf, head.len, head.secs, head.region, head.idx};
    assign m_tlast  = head.last;
    assign m_tuser  = head.kind;

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        push.v0 |-> count_reg <= QCNT_W'(OUT_DEPTH - 2))
        else $error("record pushed without room");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.v1 |-> push.v0 && push.r1.last && !push.r0.last)
        else $error("second record slot used out of order");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(OUT_DEPTH))
        else $error("queue fill count beyond depth");

endmodule
